// ----- design/hotkey_binding_matcher_core_macros.svh -----
// ----------------------------------------------------------------------------
// Hotkey binding matcher assertion macros
// Concurrent assertion wrappers, clocked on clk and held off during rst_n.
// ----------------------------------------------------------------------------
`ifndef HOTKEY_BINDING_MATCHER_CORE_MACROS_SVH
`define HOTKEY_BINDING_MATCHER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define HBMC_ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define HBMC_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`else

`define HBMC_ASSERT_IMPL(label, pre, post, msg)
`define HBMC_ASSERT_NEXT(label, pre, post, msg)

`endif

`endif

// ----- design/hbm_pkg.sv -----
// ----------------------------------------------------------------------------
// Hotkey binding matcher package
// Request and result types, codes and the keyboard chord check.
// ----------------------------------------------------------------------------
package hbm_pkg;

  localparam int DEF_NUM_ENTRIES = 16;
  localparam int KEY_W           = 64;
  localparam int CD_W            = 16;
  localparam int SLOT_W          = 4;
  localparam logic [CD_W-1:0] COOLDOWN_RESET = 16'd30;

  // request codes
  localparam logic [2:0] REQ_FRAME       = 3'd0;
  localparam logic [2:0] REQ_BIND_PAD    = 3'd1;
  localparam logic [2:0] REQ_BIND_KEYS   = 3'd2;
  localparam logic [2:0] REQ_UNBIND_PAD  = 3'd3;
  localparam logic [2:0] REQ_UNBIND_KEYS = 3'd4;

  // result codes
  localparam logic [1:0] RK_FIRED    = 2'd0;
  localparam logic [1:0] RK_STORED   = 2'd1;
  localparam logic [1:0] RK_REJECTED = 2'd2;

  // register index (paddr[2])
  localparam logic REG_COOLDOWN = 1'b0;

  typedef struct packed {
    logic [2:0]       req_type;
    logic [KEY_W-1:0] key_value;
    logic [1:0]       action_kind;
    logic [63:0]      keys_word_0;
    logic [63:0]      keys_word_1;
    logic [63:0]      keys_word_2;
    logic [63:0]      keys_word_3;
  } in_req_t;

  typedef struct packed {
    logic [1:0]        result_kind;
    logic [SLOT_W-1:0] slot;
    logic [1:0]        fired_action;
    logic              from_keyboard;
    logic              last;
  } out_res_t;

  // table entry minus the cooldown, which lives in its own store
  typedef struct packed {
    logic             keys;
    logic [KEY_W-1:0] key;
    logic [1:0]       action;
  } ent_t;

  // all nonzero codes up to the first zero byte must be pressed
  function automatic logic chord_hit(input logic [KEY_W-1:0] key,
                                     input logic [255:0] pressed);
    logic       ok;
    logic       stop;
    logic [7:0] code;
    ok   = 1'b1;
    stop = 1'b0;
    for (int j = 0; j < 8; j++) begin
      code = key[8*j +: 8];
      if (!stop) begin
        if (code == 8'd0) begin
          stop = 1'b1;
        end else if (!pressed[code]) begin
          ok   = 1'b0;
          stop = 1'b1;
        end
      end
    end
    return ok && (key != '0);
  endfunction

endpackage

// ----- design/hotkey_binding_matcher_core.sv -----
// ----------------------------------------------------------------------------
// Hotkey binding matcher core
// Hotkey table with pad/keyboard matching, cooldowns, bind and unbind.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Each request with a
// known code walks the table once, one entry per cycle through the single
// read port of each entry store, then a frame passes the pad and keyboard
// states and a bind or unbind the bind state. Results come on out_result
// with out_strobe for exactly one cycle each, at most two per request, the
// pad match before the keyboard match; the receiver cannot stall them. A new
// request may be taken while the last result is still on the ports. The
// table is free after reset with no clearing pass. The user must write
// cooldown_frames over APB only while idle; the block does not enforce it.
`include "hotkey_binding_matcher_core_macros.svh"

module hotkey_binding_matcher_core import hbm_pkg::*; #(
  parameter int NUM_ENTRIES = DEF_NUM_ENTRIES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_req_t     in_req,
  output logic        out_strobe,
  output out_res_t    out_result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CNT_W = $clog2(NUM_ENTRIES + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_PAD  = 3'd2;
  localparam logic [2:0] ST_KEY  = 3'd3;
  localparam logic [2:0] ST_BIND = 3'd4;

  logic [2:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   pv_r, pv_nxt;
  logic [IDX_W-1:0]       pidx_r;
  in_req_t                req_r;
  logic [NUM_ENTRIES-1:0] valid_r, valid_nxt;
  logic [CD_W-1:0]        cooldown_frames_r;
  logic                   out_strobe_r, out_strobe_nxt;
  out_res_t               out_res_r, out_res_nxt;

  // entry stores
  ent_t            ent_mem [NUM_ENTRIES];
  logic [CD_W-1:0] cd_mem  [NUM_ENTRIES];
  ent_t            ent_rd_r;
  logic [CD_W-1:0] cd_rd_r;

  // scan results
  logic             pad_hit_r, pad_rdy_r, key_hit_r, key_rdy_r;
  logic [IDX_W-1:0] pad_idx_r, key_idx_r;
  logic [1:0]       pad_act_r, key_act_r;
  logic             mt_hit_r, sl_hit_r;
  logic [IDX_W-1:0] mt_idx_r, sl_idx_r;

  logic             accept, cfg_wr;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             eval_on, ent_v, is_frame, is_bind, req_keys;
  logic [CD_W-1:0]  cd_dec, cd_new;
  logic             pad_m, key_m, mt_m, sl_m;
  logic             pad_fire, key_fire;
  logic             cd_we, ent_we;
  logic [IDX_W-1:0] cd_wa;
  logic [CD_W-1:0]  cd_wd;
  logic [255:0]     pressed;

  assign accept  = start && !busy;
  assign busy    = (state_r != ST_IDLE);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign prdata  = (paddr[2] == REG_COOLDOWN) ? {16'd0, cooldown_frames_r} : 32'd0;

  assign rd_en   = (state_r == ST_SCAN) && (cnt_r < CNT_W'(NUM_ENTRIES));
  assign rd_addr = cnt_r[IDX_W-1:0];

  assign pressed  = {req_r.keys_word_3, req_r.keys_word_2,
                     req_r.keys_word_1, req_r.keys_word_0};
  assign is_frame = (req_r.req_type == REQ_FRAME);
  assign is_bind  = (req_r.req_type == REQ_BIND_PAD) || (req_r.req_type == REQ_BIND_KEYS);
  assign req_keys = (req_r.req_type == REQ_BIND_KEYS) || (req_r.req_type == REQ_UNBIND_KEYS);

  // evaluation stage works on the entry read the cycle before
  assign eval_on = (state_r == ST_SCAN) && pv_r;
  assign ent_v   = valid_r[pidx_r];
  assign cd_dec  = cd_rd_r - CD_W'(1);
  assign cd_new  = (ent_v && (cd_rd_r != '0)) ? cd_dec : cd_rd_r;

  assign pad_m = eval_on && is_frame && ent_v && !ent_rd_r.keys &&
                 (ent_rd_r.key == req_r.key_value);
  assign key_m = eval_on && is_frame && ent_v && ent_rd_r.keys &&
                 chord_hit(ent_rd_r.key, pressed);
  assign mt_m  = eval_on && !is_frame && ent_v && (ent_rd_r.keys == req_keys) &&
                 (ent_rd_r.key == req_r.key_value);
  // first free slot, counting the entry being removed as free
  assign sl_m  = eval_on && !is_frame && (!ent_v || mt_m);

  assign pad_fire = pad_hit_r && pad_rdy_r;
  assign key_fire = key_hit_r && key_rdy_r;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    pv_nxt         = 1'b0;
    valid_nxt      = valid_r;
    out_strobe_nxt = 1'b0;
    out_res_nxt    = '0;
    cd_we          = 1'b0;
    cd_wa          = pidx_r;
    cd_wd          = cd_new;
    ent_we         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (accept && (in_req.req_type inside {[REQ_FRAME:REQ_UNBIND_KEYS]})) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        pv_nxt = rd_en;
        if (rd_en) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        cd_we = eval_on && is_frame && ent_v && (cd_rd_r != '0);
        if (cnt_r == CNT_W'(NUM_ENTRIES)) begin
          state_nxt = is_frame ? ST_PAD : ST_BIND;
        end
      end
      ST_PAD: begin
        cd_we = pad_fire;
        cd_wa = pad_idx_r;
        cd_wd = cooldown_frames_r;
        if (pad_fire) begin
          out_strobe_nxt            = 1'b1;
          out_res_nxt.result_kind   = RK_FIRED;
          out_res_nxt.slot          = SLOT_W'(pad_idx_r);
          out_res_nxt.fired_action  = pad_act_r;
          out_res_nxt.from_keyboard = 1'b0;
          out_res_nxt.last          = !key_fire;
        end
        state_nxt = ST_KEY;
      end
      ST_KEY: begin
        cd_we = key_fire;
        cd_wa = key_idx_r;
        cd_wd = cooldown_frames_r;
        if (key_fire) begin
          out_strobe_nxt            = 1'b1;
          out_res_nxt.result_kind   = RK_FIRED;
          out_res_nxt.slot          = SLOT_W'(key_idx_r);
          out_res_nxt.fired_action  = key_act_r;
          out_res_nxt.from_keyboard = 1'b1;
          out_res_nxt.last          = 1'b1;
        end
        state_nxt = ST_IDLE;
      end
      ST_BIND: begin
        if (mt_hit_r) begin
          valid_nxt[mt_idx_r] = 1'b0;
        end
        if (is_bind) begin
          out_strobe_nxt            = 1'b1;
          out_res_nxt.from_keyboard = req_keys;
          out_res_nxt.last          = 1'b1;
          if (sl_hit_r) begin
            valid_nxt[sl_idx_r]      = 1'b1;
            ent_we                   = 1'b1;
            cd_we                    = 1'b1;
            cd_wa                    = sl_idx_r;
            cd_wd                    = '0;
            out_res_nxt.result_kind  = RK_STORED;
            out_res_nxt.slot         = SLOT_W'(sl_idx_r);
            out_res_nxt.fired_action = req_r.action_kind;
          end else begin
            out_res_nxt.result_kind  = RK_REJECTED;
          end
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ST_IDLE;
      cnt_r             <= '0;
      pv_r              <= 1'b0;
      valid_r           <= '0;
      cooldown_frames_r <= COOLDOWN_RESET;
      out_strobe_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      pv_r         <= pv_nxt;
      valid_r      <= valid_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_wr && (paddr[2] == REG_COOLDOWN)) begin
        cooldown_frames_r <= pwdata[CD_W-1:0];
      end
    end
  end

  // request latch and first-hit tracking
  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    pidx_r    <= rd_addr;
    if (accept) begin
      req_r     <= in_req;
      pad_hit_r <= 1'b0;
      key_hit_r <= 1'b0;
      mt_hit_r  <= 1'b0;
      sl_hit_r  <= 1'b0;
    end else begin
      if (pad_m && !pad_hit_r) begin
        pad_hit_r <= 1'b1;
        pad_idx_r <= pidx_r;
        pad_rdy_r <= (cd_new == '0);
        pad_act_r <= ent_rd_r.action;
      end
      if (key_m && !key_hit_r) begin
        key_hit_r <= 1'b1;
        key_idx_r <= pidx_r;
        key_rdy_r <= (cd_new == '0);
        key_act_r <= ent_rd_r.action;
      end
      if (mt_m && !mt_hit_r) begin
        mt_hit_r <= 1'b1;
        mt_idx_r <= pidx_r;
      end
      if (sl_m && !sl_hit_r) begin
        sl_hit_r <= 1'b1;
        sl_idx_r <= pidx_r;
      end
    end
  end

  // entry stores: one read and one write port each
  always_ff @(posedge clk) begin
    if (rd_en) begin
      ent_rd_r <= ent_mem[rd_addr];
      cd_rd_r  <= cd_mem[rd_addr];
    end
    if (ent_we) begin
      ent_mem[sl_idx_r] <= '{keys: req_keys, key: req_r.key_value,
                             action: req_r.action_kind};
    end
    if (cd_we) begin
      cd_mem[cd_wa] <= cd_wd;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_result = out_res_r;

  `HBMC_ASSERT_IMPL(a_strobe_after_work, out_strobe_r, $past(state_r) != ST_IDLE, "result without work")
  `HBMC_ASSERT_NEXT(a_accept_to_scan, accept && (in_req.req_type <= REQ_UNBIND_KEYS), state_r == ST_SCAN, "request not scanned")
  `HBMC_ASSERT_IMPL(a_scan_count, state_r == ST_SCAN, cnt_r <= CNT_W'(NUM_ENTRIES), "scan count overrun")
  `HBMC_ASSERT_IMPL(a_bind_single, out_strobe_r && (out_res_r.result_kind != RK_FIRED), out_res_r.last, "bind result not last")

endmodule

// ----- test/tb_hotkey_binding_matcher_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hotkey binding matcher core testbench
// Walks a short directed table, then random bind/unbind/frame traffic under
// several cooldown settings, predicting untyped rows from a local table copy.
// ----------------------------------------------------------------------------
module tb_hotkey_binding_matcher_core;
  import hbm_pkg::*;

  localparam int TABLE_SIZE      = DEF_NUM_ENTRIES;
  localparam int DRAIN_CYCLES    = 25;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int ITEMS_PER_PHASE = 65;
  localparam int NUM_PHASES      = 6;
  localparam int POOL_SIZE       = 6;
  localparam int BY_MODEL        = -1;
  localparam int MAX_PRINTED     = 40;

  typedef enum logic [1:0] {
    SLOT_FREE = 2'd0,
    SLOT_PAD  = 2'd1,
    SLOT_KEYS = 2'd2
  } slot_kind_e;

  typedef struct {
    in_req_t  req;
    int       n_typed;
    out_res_t res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_req_t     in_req;
  logic        out_strobe;
  out_res_t    out_result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // local copy of the hotkey table
  slot_kind_e      tbl_kind [TABLE_SIZE];
  logic [63:0]     tbl_key  [TABLE_SIZE];
  logic [1:0]      tbl_act  [TABLE_SIZE];
  logic [CD_W-1:0] tbl_cd   [TABLE_SIZE];
  logic [CD_W-1:0] cd_frames;

  out_res_t  step_res [2];
  int        step_n;
  out_res_t  pending_results [$];
  out_res_t  want;

  bit        row_typed;
  int        row_cnt;
  out_res_t  row_res;

  stim_row_t   plan [$];
  logic [63:0] pad_pool   [POOL_SIZE];
  logic [63:0] chord_pool [POOL_SIZE];
  logic [CD_W-1:0] cd_plan [NUM_PHASES];

  int mismatches   = 0;
  int quiet_cycles = 0;
  int idle_pct;

  hotkey_binding_matcher_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_strobe(out_strobe),
    .out_result(out_result),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic note_mismatch(input string msg);
    if (mismatches < MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    mismatches++;
  endtask

  // ---- prediction ---------------------------------------------------------

  function automatic bit chord_held(input logic [63:0] key, input logic [255:0] down);
    bit         held;
    int         b;
    logic [7:0] code;
    held = 1'b1;
    b    = 0;
    while (b < 8 && held) begin
      code = key[8*b +: 8];
      if (code == 8'd0) break;  // zero byte terminates the chord
      held = down[code];
      b++;
    end
    return held;
  endfunction

  task automatic fire_slot(input int idx, input logic from_kb);
    if (idx >= 0 && tbl_cd[idx] == '0) begin
      tbl_cd[idx] = cd_frames;
      step_res[step_n] = '{result_kind: RK_FIRED, slot: idx[SLOT_W-1:0],
                           fired_action: tbl_act[idx], from_keyboard: from_kb,
                           last: 1'b0};
      step_n++;
    end
  endtask

  task automatic table_step(input in_req_t r);
    int           hit;
    slot_kind_e   kind;
    logic [255:0] down;
    step_n = 0;
    hit    = -1;
    case (r.req_type)
      REQ_FRAME: begin
        for (int i = 0; i < TABLE_SIZE; i++) begin
          if (tbl_kind[i] != SLOT_FREE && tbl_cd[i] != '0) tbl_cd[i]--;
        end
        for (int i = 0; i < TABLE_SIZE; i++) begin
          if (hit < 0 && tbl_kind[i] == SLOT_PAD && tbl_key[i] == r.key_value) hit = i;
        end
        fire_slot(hit, 1'b0);
        down = {r.keys_word_3, r.keys_word_2, r.keys_word_1, r.keys_word_0};
        hit  = -1;
        for (int i = 0; i < TABLE_SIZE; i++) begin
          if (hit < 0 && tbl_kind[i] == SLOT_KEYS && tbl_key[i] != '0 &&
              chord_held(tbl_key[i], down)) hit = i;
        end
        fire_slot(hit, 1'b1);
      end
      REQ_BIND_PAD, REQ_BIND_KEYS, REQ_UNBIND_PAD, REQ_UNBIND_KEYS: begin
        if (r.req_type == REQ_BIND_PAD || r.req_type == REQ_UNBIND_PAD) begin
          kind = SLOT_PAD;
        end else begin
          kind = SLOT_KEYS;
        end
        for (int i = 0; i < TABLE_SIZE; i++) begin
          if (hit < 0 && tbl_kind[i] == kind && tbl_key[i] == r.key_value) hit = i;
        end
        if (hit >= 0) begin
          tbl_kind[hit] = SLOT_FREE;
          tbl_key[hit]  = '0;
          tbl_act[hit]  = '0;
          tbl_cd[hit]   = '0;
        end
        if (r.req_type == REQ_BIND_PAD || r.req_type == REQ_BIND_KEYS) begin
          hit = -1;
          for (int i = 0; i < TABLE_SIZE; i++) begin
            if (hit < 0 && tbl_kind[i] == SLOT_FREE) hit = i;
          end
          if (hit < 0) begin
            step_res[0] = '{result_kind: RK_REJECTED, slot: '0, fired_action: 2'd0,
                            from_keyboard: (kind == SLOT_KEYS), last: 1'b0};
          end else begin
            tbl_kind[hit] = kind;
            tbl_key[hit]  = r.key_value;
            tbl_act[hit]  = r.action_kind;
            tbl_cd[hit]   = '0;
            step_res[0] = '{result_kind: RK_STORED, slot: hit[SLOT_W-1:0],
                            fired_action: r.action_kind,
                            from_keyboard: (kind == SLOT_KEYS), last: 1'b0};
          end
          step_n = 1;
        end
      end
      default: ;  // unused codes are dropped
    endcase
    if (step_n > 0) step_res[step_n-1].last = 1'b1;
  endtask

  // ---- checking -----------------------------------------------------------

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) begin
        if (pending_results.size() == 0) begin
          note_mismatch($sformatf("unexpected result kind %0d slot %0d",
                                  out_result.result_kind, out_result.slot));
        end else begin
          want = pending_results.pop_front();
          if (out_result.result_kind !== want.result_kind)
            note_mismatch($sformatf("result_kind got %0d expected %0d",
                                    out_result.result_kind, want.result_kind));
          if (out_result.slot !== want.slot)
            note_mismatch($sformatf("slot got %0d expected %0d",
                                    out_result.slot, want.slot));
          if (out_result.fired_action !== want.fired_action)
            note_mismatch($sformatf("fired_action got %0d expected %0d",
                                    out_result.fired_action, want.fired_action));
          if (out_result.from_keyboard !== want.from_keyboard)
            note_mismatch($sformatf("from_keyboard got %0d expected %0d",
                                    out_result.from_keyboard, want.from_keyboard));
          if (out_result.last !== want.last)
            note_mismatch($sformatf("last got %0d expected %0d",
                                    out_result.last, want.last));
        end
      end
      if (start && !busy) begin
        table_step(in_req);
        if (row_typed) begin
          repeat (row_cnt) pending_results.push_back(row_res);
        end else begin
          for (int i = 0; i < step_n; i++) pending_results.push_back(step_res[i]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && ((start && !busy) || out_strobe)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no request or result for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---- stimulus -----------------------------------------------------------

  function automatic in_req_t rand_req();
    in_req_t r;
    r.req_type    = 3'($urandom_range(0, 7));
    r.key_value   = {$urandom, $urandom};
    r.action_kind = 2'($urandom_range(0, 3));
    r.keys_word_0 = {$urandom, $urandom};
    r.keys_word_1 = {$urandom, $urandom};
    r.keys_word_2 = {$urandom, $urandom};
    r.keys_word_3 = {$urandom, $urandom};
    return r;
  endfunction

  function automatic logic [63:0] make_chord();
    logic [63:0] k;
    int          len;
    k   = '0;
    len = $urandom_range(1, 8);
    for (int b = 0; b < len; b++) k[8*b +: 8] = 8'($urandom_range(1, 255));
    // now and then stray codes after the terminator
    if (len < 7 && $urandom_range(0, 3) == 0) begin
      for (int b = len + 1; b < 8; b++) k[8*b +: 8] = 8'($urandom_range(0, 255));
    end
    return k;
  endfunction

  function automatic logic [255:0] keys_for(input logic [63:0] key);
    logic [255:0] down;
    down = '0;
    for (int b = 0; b < 8; b++) begin
      if (key[8*b +: 8] == 8'd0) break;
      down[key[8*b +: 8]] = 1'b1;
    end
    return down;
  endfunction

  function automatic out_res_t mk_res(input logic [1:0] kind, input logic [3:0] slot,
                                      input logic [1:0] act, input logic kb);
    return '{result_kind: kind, slot: slot, fired_action: act, from_keyboard: kb,
             last: 1'b1};
  endfunction

  task automatic add_row(input logic [2:0] op, input logic [63:0] key,
                         input logic [1:0] act, input logic [255:0] down,
                         input int n_typed, input out_res_t res);
    stim_row_t row;
    row.req.req_type    = op;
    row.req.key_value   = key;
    row.req.action_kind = act;
    {row.req.keys_word_3, row.req.keys_word_2,
     row.req.keys_word_1, row.req.keys_word_0} = down;
    row.n_typed = n_typed;
    row.res     = res;
    plan.push_back(row);
  endtask

  task automatic refresh_pools();
    for (int i = 0; i < POOL_SIZE; i++) begin
      pad_pool[i]   = (i == 0 && $urandom_range(0, 1)) ? 64'd0 : {$urandom, $urandom};
      chord_pool[i] = make_chord();
    end
  endtask

  function automatic in_req_t next_random_req();
    in_req_t      r;
    int           pick;
    int           mode;
    logic [255:0] down;
    r    = rand_req();
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      r.req_type = REQ_FRAME;
      if ($urandom_range(0, 9) < 7) r.key_value = pad_pool[$urandom_range(0, POOL_SIZE-1)];
      mode = $urandom_range(0, 99);
      if (mode < 60) begin
        down = keys_for(chord_pool[$urandom_range(0, POOL_SIZE-1)]);
        repeat ($urandom_range(0, 3)) down[$urandom_range(0, 255)] = 1'b1;
        // near miss: the first code of a random pool chord released
        if ($urandom_range(0, 4) == 0) begin
          down[chord_pool[$urandom_range(0, POOL_SIZE-1)][7:0]] = 1'b0;
        end
      end else if (mode < 75) begin
        down = '0;
      end else if (mode < 85) begin
        down = '1;
      end else begin
        down = {r.keys_word_3, r.keys_word_2, r.keys_word_1, r.keys_word_0};
      end
      {r.keys_word_3, r.keys_word_2, r.keys_word_1, r.keys_word_0} = down;
    end else if (pick < 62) begin
      r.req_type = REQ_BIND_PAD;
      if ($urandom_range(0, 4) != 0) r.key_value = pad_pool[$urandom_range(0, POOL_SIZE-1)];
    end else if (pick < 74) begin
      r.req_type = REQ_BIND_KEYS;
      if ($urandom_range(0, 4) != 0) r.key_value = chord_pool[$urandom_range(0, POOL_SIZE-1)];
    end else if (pick < 84) begin
      r.req_type = REQ_UNBIND_PAD;
      if ($urandom_range(0, 4) != 0) r.key_value = pad_pool[$urandom_range(0, POOL_SIZE-1)];
    end else if (pick < 94) begin
      r.req_type = REQ_UNBIND_KEYS;
      if ($urandom_range(0, 4) != 0) r.key_value = chord_pool[$urandom_range(0, POOL_SIZE-1)];
    end else begin
      r.req_type = 3'($urandom_range(5, 7));
    end
    return r;
  endfunction

  // ---- drivers ------------------------------------------------------------

  task automatic issue(input in_req_t r, input bit typed, input int n, input out_res_t res);
    @(negedge clk);
    start     = 1'b1;
    in_req    = r;
    row_typed = typed;
    row_cnt   = n;
    row_res   = res;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_for(input int n);
    repeat (n) begin
      @(negedge clk);
      start  = 1'b0;
      in_req = rand_req();
    end
  endtask

  task automatic drain(input int extra);
    @(negedge clk);
    start  = 1'b0;
    in_req = rand_req();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CD_W-1:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {REG_COOLDOWN, 2'b00};
    pwdata  = 32'(value);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    cd_frames = value;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    // read back
    @(negedge clk);
    psel = 1'b1;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== 32'(value))
      note_mismatch($sformatf("cooldown_frames read %0d expected %0d", prdata, value));
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // ---- sequence -----------------------------------------------------------

  initial begin
    logic [255:0] only_code;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_req    = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    row_typed = 1'b0;
    row_cnt   = 0;
    row_res   = '0;
    cd_frames = COOLDOWN_RESET;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      tbl_kind[i] = SLOT_FREE;
      tbl_key[i]  = '0;
      tbl_act[i]  = '0;
      tbl_cd[i]   = '0;
    end

    // directed table, run at the reset cooldown
    add_row(REQ_FRAME, 64'd0, 2'd0, '0, 0, '0);  // empty table
    add_row(REQ_BIND_PAD, 64'd0, 2'd1, '0, 1, mk_res(RK_STORED, 4'd0, 2'd1, 1'b0));
    // pad mask zero fires with nothing held
    add_row(REQ_FRAME, 64'd0, 2'd0, '0, 1, mk_res(RK_FIRED, 4'd0, 2'd1, 1'b0));
    add_row(REQ_BIND_KEYS, 64'h0201, 2'd2, '0, 1, mk_res(RK_STORED, 4'd1, 2'd2, 1'b1));
    add_row(REQ_BIND_KEYS, '1, 2'd3, '0, 1, mk_res(RK_STORED, 4'd2, 2'd3, 1'b1));
    add_row(REQ_BIND_PAD, '1, 2'd0, '0, 1, mk_res(RK_STORED, 4'd3, 2'd0, 1'b0));
    // zero chord is stored but never matches
    add_row(REQ_BIND_KEYS, 64'd0, 2'd3, '0, 1, mk_res(RK_STORED, 4'd4, 2'd3, 1'b1));
    add_row(REQ_FRAME, '1, 2'd0, '1, BY_MODEL, '0);
    only_code = '0;
    only_code[255] = 1'b1;
    add_row(REQ_FRAME, 64'd0, 2'd0, only_code, BY_MODEL, '0);
    add_row(REQ_UNBIND_PAD, '1, 2'd0, '0, 0, '0);
    add_row(REQ_UNBIND_KEYS, 64'h1234, 2'd0, '0, 0, '0);
    add_row(3'd5, '1, 2'd3, '1, 0, '0);
    add_row(3'd7, 64'd0, 2'd1, '0, 0, '0);
    // zero byte ends the chord, later codes ignored
    add_row(REQ_BIND_KEYS, 64'h0300_0000_0000_0005, 2'd1, '0, BY_MODEL, '0);
    only_code = '0;
    only_code[5] = 1'b1;
    add_row(REQ_FRAME, 64'd1, 2'd0, only_code, BY_MODEL, '0);
    for (int i = 0; i < TABLE_SIZE - 5; i++) begin
      add_row(REQ_BIND_PAD, 64'h100 + i, 2'(i), '0, BY_MODEL, '0);
    end
    add_row(REQ_BIND_PAD, 64'hDEAD, 2'd3, '0, 1, mk_res(RK_REJECTED, 4'd0, 2'd0, 1'b0));
    add_row(REQ_BIND_KEYS, 64'h77, 2'd2, '0, 1, mk_res(RK_REJECTED, 4'd0, 2'd0, 1'b1));
    add_row(REQ_UNBIND_PAD, 64'h104, 2'd0, '0, 0, '0);
    add_row(REQ_BIND_PAD, 64'h104, 2'd2, '0, BY_MODEL, '0);

    cd_plan = '{16'd0, 16'd3, 16'hFFFF, 16'd1, 16'd0, 16'd30};
    cd_plan[4] = 16'($urandom_range(2, 12));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].n_typed == BY_MODEL) begin
        issue(plan[i].req, 1'b0, 0, '0);
      end else begin
        issue(plan[i].req, 1'b1, plan[i].n_typed, plan[i].res);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain(DRAIN_CYCLES);
      cfg_write(cd_plan[ph]);
      idle_pct = (ph < 2) ? 15 : ((ph < 4) ? 70 : 0);
      refresh_pools();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 39) == 0) begin
          drain(0);  // hold off until every pending result is in
        end else if ($urandom_range(0, 99) < idle_pct) begin
          idle_for($urandom_range(1, 22));
        end
        issue(next_random_req(), 1'b0, 0, '0);
      end
    end

    drain(DRAIN_CYCLES);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
